>>> rtl/core/gcm_pkg.sv
// Shared types and constants for the glyph cache MRU lookup.
`default_nettype none
package gcm_pkg;

  localparam int KEY_W      = 32;
  localparam int SLOT_OUT_W = 6;
  localparam int OFFS_W     = 21;
  localparam int STRIDE_W   = 16;
  localparam int PROD_W     = 24;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } gcm_state_t;

  typedef struct packed {
    logic cmp;
    logic upd;
  } gcm_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/glyph_cache_mru_lookup.sv
// Glyph cache MRU lookup: move-to-front list held in a row of cells.
// Key is registered when start is taken; the cells register their matches in the
// compare cycle, the list shifts to front in the update cycle, and done is
// registered from the update cycle; start is taken again during the shift cycle.
// Reset clears all cell valid bits, the fill count and the stride (to 4); no sweep.
// Results cannot be stalled: done is high for exactly one cycle per lookup.
`default_nettype none
module glyph_cache_mru_lookup
  import gcm_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [KEY_W-1:0]      key,
  output logic                       done,
  output logic                       hit,
  output logic [SLOT_OUT_W-1:0]      slot,
  output logic [OFFS_W-1:0]          data_offset,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [STRIDE_W-1:0]   cfg_data
);

  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(ENTRIES);

  gcm_ctl_t ctl;
  logic     accept;

  logic [STRIDE_W-1:0] entry_bytes;
  logic [KEY_W-1:0]    key_q;
  logic [COUNT_W-1:0]  entry_count;

  logic [KEY_W-1:0]  cell_key   [ENTRIES];
  logic [SLOT_W-1:0] cell_slot  [ENTRIES];
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] cell_match;

  logic [ENTRIES-1:0] pos_plane  [SLOT_W];
  logic [ENTRIES-1:0] slot_plane [SLOT_W];
  logic [SLOT_W-1:0]  hit_pos;
  logic [SLOT_W-1:0]  hit_slot;
  logic               hit_any;
  logic [SLOT_W-1:0]  chosen;
  logic [PROD_W-1:0]  chosen_w;
  logic [PROD_W-1:0]  product;

  gcm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .accept (accept),
    .ctl    (ctl)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_bytes <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= key;
    end
  end

  // matches are unique, so position and slot of the hit come from bit planes
  for (genvar b = 0; b < SLOT_W; b++) begin : g_plane
    for (genvar i = 0; i < ENTRIES; i++) begin : g_bit
      localparam logic [SLOT_W-1:0] POS = SLOT_W'(i);
      assign pos_plane[b][i]  = cell_match[i] && POS[b];
      assign slot_plane[b][i] = cell_match[i] && cell_slot[i][b];
    end
    assign hit_pos[b]  = |pos_plane[b];
    assign hit_slot[b] = |slot_plane[b];
  end

  assign hit_any = |cell_match;

  always_comb begin
    if (hit_any) begin
      chosen = hit_slot;
    end else if (entry_count == COUNT_FULL) begin
      chosen = cell_slot[ENTRIES-1];
    end else begin
      chosen = entry_count[SLOT_W-1:0];
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]  in_key;
    logic [SLOT_W-1:0] in_slot;
    logic              in_valid;
    if (i == 0) begin : g_front
      assign in_key   = key_q;
      assign in_slot  = chosen;
      assign in_valid = 1'b1;
    end else begin : g_link
      assign in_key   = cell_key[i-1];
      assign in_slot  = cell_slot[i-1];
      assign in_valid = cell_valid[i-1];
    end
    gcm_cell #(
      .SLOT_W (SLOT_W),
      .IDX    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .probe_key (key_q),
      .hit_any   (hit_any),
      .hit_pos   (hit_pos),
      .in_key    (in_key),
      .in_slot   (in_slot),
      .in_valid  (in_valid),
      .key       (cell_key[i]),
      .slot      (cell_slot[i]),
      .valid     (cell_valid[i]),
      .match     (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.upd && !hit_any && (entry_count != COUNT_FULL)) begin
      entry_count <= entry_count + COUNT_W'(1);
    end
  end

  assign chosen_w = PROD_W'(chosen);
  assign product  = chosen_w * PROD_W'(entry_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      hit         <= hit_any;
      slot        <= chosen_w[SLOT_OUT_W-1:0];
      data_offset <= product[OFFS_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/gcm_cell.sv
// One list position: key, slot and valid, plus its registered key match.
`default_nettype none
module gcm_cell
  import gcm_pkg::*;
#(
  parameter int SLOT_W = 6,
  parameter int IDX    = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gcm_ctl_t          ctl,
  input  wire logic [KEY_W-1:0]  probe_key,
  input  wire logic              hit_any,
  input  wire logic [SLOT_W-1:0] hit_pos,
  input  wire logic [KEY_W-1:0]  in_key,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic              in_valid,
  output logic [KEY_W-1:0]       key,
  output logic [SLOT_W-1:0]      slot,
  output logic                   valid,
  output logic                   match
);

  localparam logic [SLOT_W-1:0] MY_POS = SLOT_W'(IDX);

  logic shift;

  // on a miss every cell moves down; on a hit only those up to the match
  assign shift = ctl.upd && (!hit_any || (MY_POS <= hit_pos));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        match <= valid && (key == probe_key);
      end
      if (shift) begin
        valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key  <= in_key;
      slot <= in_slot;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/gcm_ctrl.sv
// Lookup sequencer: compare cycle then list update cycle.
`default_nettype none
module gcm_ctrl
  import gcm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      accept,
  output gcm_ctl_t  ctl
);

  gcm_state_t state;
  gcm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = start ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    ctl.cmp = 1'b0;
    ctl.upd = 1'b0;
    case (state)
      ST_IDLE: begin
      end
      ST_CMP: begin
        busy    = 1'b1;
        ctl.cmp = 1'b1;
      end
      ST_UPD: begin
        ctl.upd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign accept = start && !busy;

endmodule
`default_nettype wire

>>> rtl/core/gcm_checker.sv
// Port-level timing checks for the glyph cache MRU lookup, bound to the top level.
`default_nettype none
module gcm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted lookup did not enter compare cycle");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> ##1 done)
    else $error("result missing two cycles after compare");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results closer than the lookup interval");

endmodule

bind glyph_cache_mru_lookup gcm_checker u_gcm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
